[rtl/palette_line_scaler_3_2_unit_defines.svh]
// assertion macros for the palette line scaler
`ifndef PALETTE_LINE_SCALER_3_2_UNIT_DEFINES_SVH
`define PALETTE_LINE_SCALER_3_2_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PLS_ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("pls assertion failed");
`define PLS_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("pls assertion failed");
`else
`define PLS_ASSERT_IMPLY(label, clk, rstn, cond, prop)
`define PLS_ASSERT_NEXT(label, clk, rstn, cond, prop)
`endif

`endif

[rtl/pls_pkg.sv]
// shared types, constants and color functions of the palette line scaler
`timescale 1ns / 1ps

package pls_pkg;

    localparam int SRC_WIDTH_DEF     = 160;
    localparam int OUT_WIDTH_DEF     = 240;
    localparam int OUT_HEIGHT_DEF    = 216;
    localparam int BAND_LINES_DEF    = 24;
    localparam int PALETTE_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH       = 2;

    localparam int LINE_W  = 8;
    localparam int PAIR_W  = 7;
    localparam int PIXEL_W = 8;
    localparam int PIDX_W  = 6;
    localparam int PALI_W  = 7;
    localparam int COLOR_W = 16;
    localparam int BROW_W  = 9;
    localparam int PADDR_W = 3;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_PAL   = 1'b1;

    localparam logic REG_Y_OFFSET = 1'b0;

    localparam logic [COLOR_W-1:0] BLEND_MASK = 16'hF7DE;

    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic [PAIR_W-1:0]  pair;
        logic [COLOR_W-1:0] px_left;
        logic [COLOR_W-1:0] px_center;
        logic [COLOR_W-1:0] px_right;
    } pls_entry_t;

    typedef struct packed {
        logic [7:0]         out_row;
        logic [7:0]         out_col;
        logic [COLOR_W-1:0] main_left;
        logic [COLOR_W-1:0] main_center;
        logic [COLOR_W-1:0] main_right;
        logic [COLOR_W-1:0] mid_left;
        logic [COLOR_W-1:0] mid_center;
        logic [COLOR_W-1:0] mid_right;
        logic               has_mid;
        logic               band_done;
        logic               band_buffer;
        logic [BROW_W-1:0]  band_row;
    } pls_result_t;

    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // 15-bit palette word to rgb565, red and blue swapped
    function automatic logic [COLOR_W-1:0] to_rgb565(input logic [COLOR_W-1:0] w);
        return {w[4:0], w[9:5], 1'b0, w[14:10]};
    endfunction

    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
        return (((a ^ b) & BLEND_MASK) >> 1) + (a & b);
    endfunction

endpackage

[rtl/pls_ram.sv]
// generic single write port ram with one registered read port
`timescale 1ns / 1ps

module pls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pls_front.sv]
// front end: accepts words, writes the palette, looks up pair colors
`timescale 1ns / 1ps

module pls_front import pls_pkg::*; #(
    parameter int SRC_WIDTH     = SRC_WIDTH_DEF,
    parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               func,
    input  logic [LINE_W-1:0]  line,
    input  logic [PAIR_W-1:0]  pair,
    input  logic [PIXEL_W-1:0] pixel_a,
    input  logic [PIXEL_W-1:0] pixel_b,
    input  logic [PALI_W-1:0]  pal_index,
    input  logic [PIXEL_W-1:0] pal_byte,
    output logic               push_valid,
    input  logic               push_ready,
    output pls_entry_t         push_entry
);

    localparam logic [PAIR_W:0] PAIRS  = (PAIR_W+1)'(SRC_WIDTH / 2);
    localparam int              LO_D   = (PALETTE_BYTES + 1) / 2;
    localparam int              HI_D   = PALETTE_BYTES / 2;
    localparam int              LO_AW  = addr_bits(LO_D);
    localparam int              HI_AW  = addr_bits(HI_D);

    logic              accept, is_pal, pair_ok, pal_ok, load;
    logic              we_lo, we_hi;
    logic [PALI_W-2:0] pal_word;
    logic [PIDX_W-1:0] idx_a, idx_b;
    logic [3:0]        ok_in;
    logic [PIXEL_W-1:0] lo_a, lo_b, hi_a, hi_b;
    logic [COLOR_W-1:0] w_a, w_b, col_a, col_b;

    logic               f_valid_reg, f_valid_next;
    logic [LINE_W-1:0]  f_line_reg;
    logic [PAIR_W-1:0]  f_pair_reg;
    logic [3:0]         f_ok_reg;

    assign s_ready  = !f_valid_reg || push_ready;
    assign accept   = s_valid && s_ready;
    assign is_pal   = (func == FUNC_PAL);
    assign pair_ok  = {1'b0, pair} < PAIRS;
    assign pal_ok   = {1'b0, pal_index} < (PALI_W+1)'(PALETTE_BYTES);
    assign load     = accept && !is_pal && pair_ok;
    assign we_lo    = accept && is_pal && pal_ok && !pal_index[0];
    assign we_hi    = accept && is_pal && pal_ok && pal_index[0];
    assign pal_word = pal_index[PALI_W-1:1];

    assign idx_a = pixel_a[PIDX_W-1:0];
    assign idx_b = pixel_b[PIDX_W-1:0];

    // order: lo a, lo b, hi a, hi b
    assign ok_in[0] = {1'b0, idx_a} < (PIDX_W+1)'(LO_D);
    assign ok_in[1] = {1'b0, idx_b} < (PIDX_W+1)'(LO_D);
    assign ok_in[2] = {1'b0, idx_a} < (PIDX_W+1)'(HI_D);
    assign ok_in[3] = {1'b0, idx_b} < (PIDX_W+1)'(HI_D);

    pls_ram #(.WIDTH(PIXEL_W), .DEPTH(LO_D)) u_lo_a (
        .aclk(aclk), .we(we_lo), .waddr(pal_word[LO_AW-1:0]), .wdata(pal_byte),
        .re(load), .raddr(idx_a[LO_AW-1:0]), .rdata(lo_a)
    );
    pls_ram #(.WIDTH(PIXEL_W), .DEPTH(LO_D)) u_lo_b (
        .aclk(aclk), .we(we_lo), .waddr(pal_word[LO_AW-1:0]), .wdata(pal_byte),
        .re(load), .raddr(idx_b[LO_AW-1:0]), .rdata(lo_b)
    );
    pls_ram #(.WIDTH(PIXEL_W), .DEPTH(HI_D)) u_hi_a (
        .aclk(aclk), .we(we_hi), .waddr(pal_word[HI_AW-1:0]), .wdata(pal_byte),
        .re(load), .raddr(idx_a[HI_AW-1:0]), .rdata(hi_a)
    );
    pls_ram #(.WIDTH(PIXEL_W), .DEPTH(HI_D)) u_hi_b (
        .aclk(aclk), .we(we_hi), .waddr(pal_word[HI_AW-1:0]), .wdata(pal_byte),
        .re(load), .raddr(idx_b[HI_AW-1:0]), .rdata(hi_b)
    );

    assign f_valid_next = load || (f_valid_reg && !push_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            f_line_reg <= line;
            f_pair_reg <= pair;
            f_ok_reg   <= ok_in;
        end
    end

    always_comb begin
        w_a = {f_ok_reg[2] ? hi_a : '0, f_ok_reg[0] ? lo_a : '0};
        w_b = {f_ok_reg[3] ? hi_b : '0, f_ok_reg[1] ? lo_b : '0};
        col_a = to_rgb565(w_a);
        col_b = to_rgb565(w_b);
    end

    assign push_valid           = f_valid_reg;
    assign push_entry.line      = f_line_reg;
    assign push_entry.pair      = f_pair_reg;
    assign push_entry.px_left   = col_a;
    assign push_entry.px_center = blend(col_a, col_b);
    assign push_entry.px_right  = col_b;

endmodule

[rtl/pls_queue.sv]
// short queue of pixel pair entries between front and back end
`timescale 1ns / 1ps

module pls_queue import pls_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pls_entry_t in_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output pls_entry_t out_entry
);

    localparam int AW = addr_bits(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pls_entry_t    slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[rtl/pls_back.sv]
// back end: row and band counters, stored row interpolation, result register
`timescale 1ns / 1ps

module pls_back import pls_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
    parameter int BAND_LINES = BAND_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  y_offset,
    input  logic        in_valid,
    output logic        in_ready,
    input  pls_entry_t  in_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output pls_result_t out_res
);

    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(SRC_WIDTH / 2 - 1);
    localparam int                VN        = (OUT_WIDTH + 2) / 3;
    localparam int                VAW       = addr_bits(VN);

    // counters
    logic [7:0] row_cnt_reg, row_cnt_next;
    logic [5:0] band_cnt_reg, band_cnt_next;
    logic [7:0] band_start_reg, band_start_next;
    logic       buf_sel_reg, buf_sel_next;

    // pop stage
    logic               b1_valid_reg, b1_valid_next;
    pls_entry_t         b1_entry_reg;
    logic [7:0]         b1_row_reg, b1_col_reg;
    logic               b1_done_reg, b1_buf_reg;
    logic [BROW_W-1:0]  b1_brow_reg;
    logic [2:0]         b1_inr_reg;
    logic               b1_vld_reg, b1_fwd_reg;
    logic [COLOR_W-1:0] b1_fwd_px_reg [3];

    logic [VN-1:0]      row_vld_reg;

    logic               m_valid_reg;
    pls_result_t        m_res_reg;

    logic               pop, move, odd, zero_line, last, flush, same_pair;
    logic [7:0]         cy, y0, cy2, mult;
    logic [5:0]         cnt, cnt2;
    logic [2:0]         inr;
    logic               vld_rd;
    logic [COLOR_W-1:0] head_px [3];
    logic [COLOR_W-1:0] b1_px [3];
    logic [COLOR_W-1:0] rdata [3];
    logic [COLOR_W-1:0] prev_px [3];
    logic [COLOR_W-1:0] mid_px [3];
    logic [VAW-1:0]     vidx_rd, vidx_wr;

    assign move     = b1_valid_reg && (!m_valid_reg || out_ready);
    assign in_ready = !b1_valid_reg || move;
    assign pop      = in_valid && in_ready;

    assign head_px[0] = in_entry.px_left;
    assign head_px[1] = in_entry.px_center;
    assign head_px[2] = in_entry.px_right;
    assign b1_px[0]   = b1_entry_reg.px_left;
    assign b1_px[1]   = b1_entry_reg.px_center;
    assign b1_px[2]   = b1_entry_reg.px_right;

    always_comb begin
        odd       = in_entry.line[0];
        zero_line = in_entry.line == '0;
        cy        = zero_line ? '0 : row_cnt_reg;
        cnt       = zero_line ? '0 : band_cnt_reg;
        y0        = (cnt == '0) ? cy : band_start_reg;
        last      = in_entry.pair == LAST_PAIR;
        mult      = {6'b0, odd, !odd};
        cnt2      = cnt + mult[5:0];
        cy2       = cy + mult;
        flush     = last && (cnt2 == 6'(BAND_LINES));

        row_cnt_next    = row_cnt_reg;
        band_cnt_next   = band_cnt_reg;
        band_start_next = band_start_reg;
        buf_sel_next    = buf_sel_reg;
        if (pop && last) begin
            band_start_next = y0;
            if (flush) begin
                buf_sel_next  = !buf_sel_reg;
                band_cnt_next = '0;
                row_cnt_next  = (cy2 == 8'(OUT_HEIGHT)) ? '0 : cy2;
            end else begin
                band_cnt_next = cnt2;
                row_cnt_next  = cy2;
            end
        end
    end

    // stored row split in three banks, bank k holds column 3*pair+k
    for (genvar k = 0; k < 3; k++) begin : g_bank
        localparam int D  = (OUT_WIDTH - k + 2) / 3;
        localparam int AW = addr_bits(D);

        assign inr[k] = {1'b0, in_entry.pair} < (PAIR_W+1)'(D);

        pls_ram #(.WIDTH(COLOR_W), .DEPTH(D)) u_row (
            .aclk (aclk),
            .we   (move && b1_inr_reg[k]),
            .waddr(b1_entry_reg.pair[AW-1:0]),
            .wdata(b1_px[k]),
            .re   (pop),
            .raddr(in_entry.pair[AW-1:0]),
            .rdata(rdata[k])
        );

        always_comb begin
            if (!b1_inr_reg[k]) begin
                prev_px[k] = '0;
            end else if (b1_fwd_reg) begin
                prev_px[k] = b1_fwd_px_reg[k];
            end else if (b1_vld_reg) begin
                prev_px[k] = rdata[k];
            end else begin
                prev_px[k] = '0;
            end
            mid_px[k] = b1_entry_reg.line[0] ? blend(prev_px[k], b1_px[k]) : '0;
        end
    end

    assign vidx_rd   = in_entry.pair[VAW-1:0];
    assign vidx_wr   = b1_entry_reg.pair[VAW-1:0];
    assign vld_rd    = inr[0] && row_vld_reg[vidx_rd];
    assign same_pair = move && (b1_entry_reg.pair == in_entry.pair);

    assign b1_valid_next = pop || (b1_valid_reg && !move);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg    <= '0;
            band_cnt_reg   <= '0;
            band_start_reg <= '0;
            buf_sel_reg    <= 1'b0;
            b1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            row_vld_reg    <= '0;
        end else begin
            row_cnt_reg    <= row_cnt_next;
            band_cnt_reg   <= band_cnt_next;
            band_start_reg <= band_start_next;
            buf_sel_reg    <= buf_sel_next;
            b1_valid_reg   <= b1_valid_next;
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (move && b1_inr_reg[0]) begin
                row_vld_reg[vidx_wr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_entry_reg <= in_entry;
            b1_row_reg   <= cy + {7'b0, odd};
            b1_col_reg   <= {in_entry.pair, 1'b0} + {1'b0, in_entry.pair};
            b1_done_reg  <= flush;
            b1_buf_reg   <= flush && buf_sel_reg;
            b1_brow_reg  <= flush ? ({1'b0, y_offset} + {1'b0, y0}) : '0;
            b1_inr_reg   <= inr;
            b1_vld_reg   <= vld_rd;
            b1_fwd_reg   <= same_pair;
            for (int k = 0; k < 3; k++) begin
                b1_fwd_px_reg[k] <= b1_px[k];
            end
        end
        if (move) begin
            m_res_reg.out_row     <= b1_row_reg;
            m_res_reg.out_col     <= b1_col_reg;
            m_res_reg.main_left   <= b1_px[0];
            m_res_reg.main_center <= b1_px[1];
            m_res_reg.main_right  <= b1_px[2];
            m_res_reg.mid_left    <= mid_px[0];
            m_res_reg.mid_center  <= mid_px[1];
            m_res_reg.mid_right   <= mid_px[2];
            m_res_reg.has_mid     <= b1_entry_reg.line[0];
            m_res_reg.band_done   <= b1_done_reg;
            m_res_reg.band_buffer <= b1_buf_reg;
            m_res_reg.band_row    <= b1_brow_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_res   = m_res_reg;

endmodule

[rtl/palette_line_scaler_3_2_unit.sv]
// top level of the palette line scaler: config port, front, queue, back
//
//  channel  dir   handshake           payload
//  s_       in    s_tvalid/s_tready   s_tdata pixel pair or palette byte, s_tuser func
//  m_       out   m_tvalid/m_tready   m_tdata three main and three mid pixels, band info
//  apb      in    psel/penable        y_offset at byte address 0
//
//  one word per cycle sustained while m_tready stays high; an accepted pixel pair then moves
//  through palette lookup, queue slot and stored row read, one register each, then the result
//  palette writes and out-of-range pairs give no result word
//  aresetn is synchronous; the stored row reads as zero after reset through valid bits
//  either side may stall; the two-entry queue decouples front and back
`timescale 1ns / 1ps
`include "palette_line_scaler_3_2_unit_defines.svh"

module palette_line_scaler_3_2_unit import pls_pkg::*; #(
    parameter int SRC_WIDTH     = SRC_WIDTH_DEF,
    parameter int OUT_WIDTH     = OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT    = OUT_HEIGHT_DEF,
    parameter int BAND_LINES    = BAND_LINES_DEF,
    parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // low to high: line, pair_index, pixel_a, pixel_b, pal_index, pal_byte
    input  logic [47:0]        s_tdata,
    // func
    input  logic [0:0]         s_tuser,
    input  logic               s_tvalid,
    output logic               s_tready,
    // low to high: out_row, out_col, main_left, main_center, main_right,
    // mid_left, mid_center, mid_right, has_mid, band_done, band_buffer, band_row
    output logic [127:0]       m_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [7:0] LAST_COL = 8'(3 * (SRC_WIDTH / 2 - 1));

    logic [7:0]  y_offset_reg;
    logic        cfg_wr;
    logic        q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    pls_entry_t  q_in_entry, q_out_entry;
    pls_result_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_Y_OFFSET);
    assign prdata = (paddr[2] == REG_Y_OFFSET) ? {24'b0, y_offset_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_offset_reg <= '0;
        end else if (cfg_wr) begin
            y_offset_reg <= pwdata[7:0];
        end
    end

    pls_front #(.SRC_WIDTH(SRC_WIDTH), .PALETTE_BYTES(PALETTE_BYTES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .func      (s_tuser[0]),
        .line      (s_tdata[7:0]),
        .pair      (s_tdata[14:8]),
        .pixel_a   (s_tdata[22:15]),
        .pixel_b   (s_tdata[30:23]),
        .pal_index (s_tdata[37:31]),
        .pal_byte  (s_tdata[45:38]),
        .push_valid(q_in_valid),
        .push_ready(q_in_ready),
        .push_entry(q_in_entry)
    );

    pls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_in_valid),
        .in_ready (q_in_ready),
        .in_entry (q_in_entry),
        .out_valid(q_out_valid),
        .out_ready(q_out_ready),
        .out_entry(q_out_entry)
    );

    pls_back #(
        .SRC_WIDTH (SRC_WIDTH),
        .OUT_WIDTH (OUT_WIDTH),
        .OUT_HEIGHT(OUT_HEIGHT),
        .BAND_LINES(BAND_LINES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .y_offset (y_offset_reg),
        .in_valid (q_out_valid),
        .in_ready (q_out_ready),
        .in_entry (q_out_entry),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

    assign m_tdata = {4'b0, res.band_row, res.band_buffer, res.band_done, res.has_mid,
                      res.mid_right, res.mid_center, res.mid_left,
                      res.main_right, res.main_center, res.main_left,
                      res.out_col, res.out_row};

    `PLS_ASSERT_IMPLY(a_flush_last, aclk, aresetn, m_tvalid && res.band_done, res.out_col == LAST_COL)
    `PLS_ASSERT_IMPLY(a_no_mid, aclk, aresetn, m_tvalid && !res.has_mid, m_tdata[111:64] == '0)
    `PLS_ASSERT_IMPLY(a_idle_band, aclk, aresetn, m_tvalid && !res.band_done, m_tdata[123:114] == '0)

endmodule

[test/tb_palette_line_scaler_3_2_unit.sv]
// testbench for the palette line scaler: stream stimulus, scaled-pixel predictor and checker
`timescale 1ns / 1ps

module tb_palette_line_scaler_3_2_unit;
    import pls_pkg::*;

    localparam int OUT_W          = OUT_WIDTH_DEF;
    localparam int PAIRS          = SRC_WIDTH_DEF / 2;
    localparam logic [6:0] LAST_PAIR = 7'(SRC_WIDTH_DEF / 2 - 1);
    localparam int DRAIN_CYCLES   = 8;
    localparam int END_CYCLES     = 20;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 40;
    localparam logic [PADDR_W-1:0] Y_OFFSET_ADDR = PADDR_W'(4 * REG_Y_OFFSET);

    logic               aclk;
    logic               aresetn;
    logic [47:0]        s_tdata;
    logic [0:0]         s_tuser;
    logic               s_tvalid;
    logic               s_tready;
    logic [127:0]       m_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    palette_line_scaler_3_2_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [7:0]  pal_mem [0:127];
    logic [15:0] row_mem [0:OUT_W-1];
    logic [7:0]  row_cnt;
    logic [5:0]  band_cnt;
    logic [7:0]  band_start;
    logic        buf_sel;
    logic [7:0]  y_off;

    pls_result_t scaled_q [$];
    int          err_count;
    int          stall_cycles;
    int          rx_hold;
    bit          tx_idle_en;
    bit          rx_idle_en;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch: %s", msg);
        end
        err_count++;
    endtask

    function automatic logic [15:0] pal_color(input logic [7:0] px);
        logic [15:0] w;
        w = {pal_mem[{px[5:0], 1'b1}], pal_mem[{px[5:0], 1'b0}]};
        return ((w & 16'h001F) << 11) | ((w & 16'h03E0) << 1) | ((w >> 10) & 16'h001F);
    endfunction

    function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b);
        return (((a ^ b) & BLEND_MASK) >> 1) + (a & b);
    endfunction

    function automatic logic [47:0] pack_word(input logic [7:0] line, input logic [6:0] pair,
                                             input logic [7:0] pa, input logic [7:0] pb,
                                             input logic [6:0] pidx, input logic [7:0] pbyte);
        return {2'b00, pbyte, pidx, pb, pa, pair, line};
    endfunction

    function automatic pls_result_t unpack_scaled(input logic [127:0] d);
        pls_result_t r;
        r.out_row     = d[7:0];
        r.out_col     = d[15:8];
        r.main_left   = d[31:16];
        r.main_center = d[47:32];
        r.main_right  = d[63:48];
        r.mid_left    = d[79:64];
        r.mid_center  = d[95:80];
        r.mid_right   = d[111:96];
        r.has_mid     = d[112];
        r.band_done   = d[113];
        r.band_buffer = d[114];
        r.band_row    = d[123:115];
        return r;
    endfunction

    task automatic scale_predict(input logic func, input logic [47:0] d);
        logic [7:0]  line;
        logic [6:0]  pair;
        logic [15:0] main_px [3];
        logic [15:0] mid_px [3];
        logic [15:0] prev;
        pls_result_t r;
        int          cy;
        int          cnt;
        int          y0;
        int          col;
        int          step;
        line = d[7:0];
        pair = d[14:8];
        if (func == FUNC_PAL) begin
            pal_mem[d[37:31]] = d[45:38];
            return;
        end
        if (pair > LAST_PAIR) begin
            return;
        end
        r   = '0;
        cy  = (line == 0) ? 0 : int'(row_cnt);
        cnt = (line == 0) ? 0 : int'(band_cnt);
        y0  = (cnt == 0) ? cy : int'(band_start);
        main_px[0] = pal_color(d[22:15]);
        main_px[2] = pal_color(d[30:23]);
        main_px[1] = mix(main_px[0], main_px[2]);
        for (int k = 0; k < 3; k++) begin
            col  = 3 * pair + k;
            prev = (col < OUT_W) ? row_mem[col] : 16'h0000;
            mid_px[k] = line[0] ? mix(prev, main_px[k]) : 16'h0000;
            if (col < OUT_W) begin
                row_mem[col] = main_px[k];
            end
        end
        r.out_row = 8'(cy + line[0]);
        r.out_col = 8'(3 * pair);
        if (pair == LAST_PAIR) begin
            step       = line[0] ? 2 : 1;
            cnt        = (cnt + step) & 63;
            cy         = (cy + step) & 255;
            band_start = 8'(y0);
            if (cnt == BAND_LINES_DEF) begin
                r.band_done   = 1'b1;
                r.band_buffer = buf_sel;
                r.band_row    = BROW_W'(int'(y_off) + y0);
                buf_sel       = ~buf_sel;
                cnt           = 0;
                if (cy == OUT_HEIGHT_DEF) begin
                    cy = 0;
                end
            end
            band_cnt = 6'(cnt);
            row_cnt  = 8'(cy);
        end
        r.main_left   = main_px[0];
        r.main_center = main_px[1];
        r.main_right  = main_px[2];
        r.mid_left    = mid_px[0];
        r.mid_center  = mid_px[1];
        r.mid_right   = mid_px[2];
        r.has_mid     = line[0];
        scaled_q.push_back(r);
    endtask

    task automatic send_word(input logic func, input logic [47:0] d);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        scale_predict(func, d);
    endtask

    task automatic send_pair(input logic [7:0] line, input logic [6:0] pair,
                             input logic [7:0] pa, input logic [7:0] pb);
        send_word(FUNC_PIXEL, pack_word(line, pair, pa, pb, 7'($urandom), 8'($urandom)));
    endtask

    task automatic send_pal(input logic [6:0] pidx, input logic [7:0] pbyte);
        send_word(FUNC_PAL, pack_word(8'($urandom), 7'($urandom), 8'($urandom), 8'($urandom),
                                      pidx, pbyte));
    endtask

    // extra random pairs or noise words, then the pair that closes the line
    task automatic send_line(input logic [7:0] line, input int extra);
        repeat (extra) begin
            if ($urandom_range(0, 9) == 0) begin
                send_pal(7'($urandom), 8'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
                send_pair(line, 7'($urandom_range(PAIRS, 127)), 8'($urandom), 8'($urandom));
            end else begin
                send_pair(line, 7'($urandom_range(0, PAIRS - 2)), 8'($urandom), 8'($urandom));
            end
        end
        send_pair(line, LAST_PAIR, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (scaled_q.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_y_offset(input logic [7:0] v);
        wait_idle(DRAIN_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= Y_OFFSET_ADDR;
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        y_off = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[7:0] !== v) begin
            report($sformatf("y_offset read 0x%0h expected 0x%0h", prdata[7:0], v));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_palette_load();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int a = 0; a < 128; a++) begin
            if (a < 2) begin
                send_pal(7'(a), 8'h00);
            end else if (a >= 126) begin
                send_pal(7'(a), 8'hFF);
            end else begin
                send_pal(7'(a), 8'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        send_pair(8'd1, 7'd0, 8'h00, 8'h3F);       // odd line against cleared row
        send_pair(8'd0, 7'd0, 8'hFF, 8'hC0);       // upper pixel bits ignored
        send_pair(8'd1, 7'd0, 8'h3F, 8'h00);
        send_pair(8'd2, LAST_PAIR, 8'h80, 8'h7F);
        send_pair(8'd3, LAST_PAIR, 8'h01, 8'hFE);
        send_pair(8'd143, LAST_PAIR, 8'h3E, 8'h41);
        send_pair(8'd255, LAST_PAIR, 8'hAA, 8'h55);
        send_pair(8'd0, 7'(PAIRS), 8'h12, 8'h34);  // pair out of range
        send_pair(8'd7, 7'd127, 8'hFF, 8'hFF);
        send_pal(7'd127, 8'h00);
        send_pair(8'd5, 7'd10, 8'h3F, 8'h3F);
        send_pal(7'd127, 8'hFF);
        send_pair(8'd5, 7'd10, 8'h3F, 8'h3F);
        send_pair(8'd0, LAST_PAIR, 8'h55, 8'hAA);  // line zero restarts counters
        send_pair(8'd1, LAST_PAIR, 8'h0F, 8'hF0);
    endtask

    task automatic test_frame();
        set_y_offset(8'hFF);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int ln = 0; ln < 144; ln++) begin
            if (ln == 72) begin
                wait_idle(0);
            end
            if (ln == 100) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_line(8'(ln), (ln % 8 == 0) ? 1 : 0);
        end
    endtask

    task automatic test_backpressure();
        set_y_offset(8'($urandom));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        rx_hold    = LONG_HOLD;
        for (int ln = 0; ln < 15; ln++) begin
            send_line(8'(ln), 1);
        end
    endtask

    // odd lines skip the band limit so the band and row counters wrap
    task automatic test_counter_wrap();
        set_y_offset(8'h00);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        send_pair(8'd0, LAST_PAIR, 8'($urandom), 8'($urandom));
        repeat (130) begin
            send_pair({7'($urandom), 1'b1}, LAST_PAIR, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_noise();
        set_y_offset(8'($urandom_range(1, 254)));
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (30) begin
            send_word(1'($urandom), {2'b00, 46'({$urandom, $urandom})});
        end
    endtask

    // result side: draws a stall per word, or takes a long hold when asked
    initial begin : rx_side
        int n;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
            end else begin
                n = rx_idle_en ? $urandom_range(0, 9) : 0;
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic cmp(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge aclk) begin : result_check
        pls_result_t got;
        pls_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_scaled(m_tdata);
            if (scaled_q.size() == 0) begin
                report($sformatf("unexpected word row %0d col %0d", got.out_row, got.out_col));
            end else begin
                want = scaled_q.pop_front();
                cmp("out_row", got.out_row, want.out_row);
                cmp("out_col", got.out_col, want.out_col);
                cmp("main_left", got.main_left, want.main_left);
                cmp("main_center", got.main_center, want.main_center);
                cmp("main_right", got.main_right, want.main_right);
                cmp("mid_left", got.mid_left, want.mid_left);
                cmp("mid_center", got.mid_center, want.mid_center);
                cmp("mid_right", got.mid_right, want.mid_right);
                cmp("has_mid", got.has_mid, want.has_mid);
                cmp("band_done", got.band_done, want.band_done);
                cmp("band_buffer", got.band_buffer, want.band_buffer);
                cmp("band_row", got.band_row, want.band_row);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_palette_line_scaler_3_2_unit failed");
            $finish;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        err_count    = 0;
        stall_cycles = 0;
        rx_hold      = 0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        for (int i = 0; i < 128; i++) begin
            pal_mem[i] = 8'h00;
        end
        for (int i = 0; i < OUT_W; i++) begin
            row_mem[i] = 16'h0000;
        end
        row_cnt    = '0;
        band_cnt   = '0;
        band_start = '0;
        buf_sel    = 1'b0;
        y_off      = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_palette_load();
        test_directed();
        test_frame();
        test_backpressure();
        test_counter_wrap();
        test_noise();

        wait_idle(END_CYCLES);
        if (err_count == 0) begin
            $display("tb_palette_line_scaler_3_2_unit passed");
        end else begin
            $display("tb_palette_line_scaler_3_2_unit failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_front.sv
rtl/pls_queue.sv
rtl/pls_back.sv
rtl/palette_line_scaler_3_2_unit.sv
test/tb_palette_line_scaler_3_2_unit.sv
